FILE: hw/rtl/bfd_pkg.sv
package bfd_pkg;

    // Preamble and CRC constants
    localparam logic [7:0]  SYNC_A   = 8'hAA;
    localparam logic [7:0]  SYNC_B   = 8'h44;
    localparam logic [7:0]  SYNC_C   = 8'h12;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    // Header layout (byte offsets from the first preamble byte)
    localparam int HDR_FIRST  = 4;   // count after preamble and length byte
    localparam int HDR_ID_LO  = 4;
    localparam int HDR_ID_HI  = 5;
    localparam int HDR_LEN_LO = 8;
    localparam int HDR_LEN_HI = 9;
    localparam logic [7:0] HLEN_MIN = 8'd5;

    typedef enum logic [3:0] {
        PH_SYNC_A = 4'd0,
        PH_SYNC_B = 4'd1,
        PH_SYNC_C = 4'd2,
        PH_HLEN   = 4'd3,
        PH_HEAD   = 4'd4,
        PH_DATA   = 4'd5,
        PH_CRC0   = 4'd6,
        PH_CRC1   = 4'd7,
        PH_CRC2   = 4'd8,
        PH_CRC3   = 4'd9
    } phase_t;

    // Input register contents handed to the parser
    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
    } in_item_t;

    // One result
    typedef struct packed {
        logic [7:0]  byte_value;
        logic        is_payload;
        logic [7:0]  payload_index;
        logic        frame_done;
        logic        crc_ok;
        logic [15:0] message_id;
        logic [8:0]  frame_length;
        logic        framing_error;
    } result_t;

    // Reflected CRC-32, one byte, LSB first
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] t;
        t = {24'd0, crc[7:0] ^ b};
        for (int k = 0; k < 8; k++) begin
            t = t[0] ? ((t >> 1) ^ CRC_POLY) : (t >> 1);
        end
        return {8'd0, crc[31:8]} ^ t;
    endfunction

    // CRC after the three preamble bytes from a zero start
    localparam logic [31:0] SYNC_CRC = crc_byte(crc_byte(crc_byte(32'd0, SYNC_A), SYNC_B), SYNC_C);

endpackage

FILE: hw/rtl/bfd_in_reg.sv
module bfd_in_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_rx_byte,
    input  logic              take,
    output bfd_pkg::in_item_t item
);
    import bfd_pkg::*;

    logic       valid_reg;
    logic [7:0] byte_reg;

    // Free slot, or the held byte leaves this cycle
    assign s_ready = !valid_reg || take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (take) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_rx_byte;
        end
    end

    assign item.valid   = valid_reg;
    assign item.rx_byte = byte_reg;

endmodule

FILE: hw/rtl/bfd_crc_unit.sv
module bfd_crc_unit (
    input  logic        seed_sel,    // first header byte after preamble
    input  logic [31:0] crc_in,
    input  logic [7:0]  data_in,
    output logic [31:0] crc_out
);
    import bfd_pkg::*;

    logic [31:0] seed;
    logic [31:0] t;

    // Length byte continues from the fixed preamble CRC
    assign seed = seed_sel ? SYNC_CRC : crc_in;

    always_comb begin
        t = {24'd0, seed[7:0] ^ data_in};
        for (int k = 0; k < 8; k++) begin
            t = t[0] ? ((t >> 1) ^ CRC_POLY) : (t >> 1);
        end
        crc_out = {8'd0, seed[31:8]} ^ t;
    end

endmodule

FILE: hw/rtl/bfd_parser.sv
module bfd_parser #(
    parameter int MAX_FRAME  = 256,
    parameter int HEADER_MAX = 28
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  bfd_pkg::in_item_t item,
    output logic              take,
    output logic              m_valid,
    input  logic              m_ready,
    output bfd_pkg::result_t  result
);
    import bfd_pkg::*;

    localparam int CNT_MAX = (MAX_FRAME > HEADER_MAX) ? MAX_FRAME : HEADER_MAX;
    localparam int CW      = $clog2(CNT_MAX + 1);
    localparam int LW      = (CW > 8) ? CW : 8;
    localparam int FW      = (CW > 9) ? CW : 9;

    phase_t      phase_reg, phase_next;
    logic [CW-1:0] count_reg, count_next;
    logic [7:0]  hlen_reg, hlen_next;
    logic [15:0] plen_reg, plen_next;
    logic [15:0] ident_reg, ident_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] rcrc_reg, rcrc_next;
    logic        out_valid_reg;
    result_t     res_reg, res_next;

    logic [7:0]    b;
    logic [CW-1:0] count_inc;
    logic          head_full, head_end, frame_full, data_end;
    logic [16:0]   frame_end;
    logic [LW-1:0] pidx_full;
    logic [FW-1:0] flen_full;
    logic [31:0]   crc_upd;
    logic [31:0]   rcrc_final;

    assign b    = item.rx_byte;
    assign take = item.valid && (!out_valid_reg || m_ready);

    bfd_crc_unit u_crc (
        .seed_sel (phase_reg == PH_HLEN),
        .crc_in   (crc_reg),
        .data_in  (b),
        .crc_out  (crc_upd)
    );

    assign count_inc  = count_reg + CW'(1);
    assign head_full  = count_reg >= CW'(HEADER_MAX);
    assign head_end   = LW'(count_inc) >= LW'(hlen_reg);
    assign frame_full = count_reg >= CW'(MAX_FRAME);
    assign frame_end  = {1'b0, plen_reg} + {9'd0, hlen_reg};
    assign data_end   = 17'(count_inc) >= frame_end;
    assign pidx_full  = LW'(count_reg) - LW'(hlen_reg);
    assign flen_full  = FW'(count_reg);
    assign rcrc_final = {b, rcrc_reg[23:0]};

    // Phase sequencing
    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_SYNC_A: if (b == SYNC_A) phase_next = PH_SYNC_B;
            PH_SYNC_B: phase_next = (b == SYNC_B) ? PH_SYNC_C : PH_SYNC_A;
            PH_SYNC_C: phase_next = (b == SYNC_C) ? PH_HLEN : PH_SYNC_A;
            PH_HLEN:   phase_next = (b < HLEN_MIN) ? PH_SYNC_A : PH_HEAD;
            PH_HEAD: begin
                if (head_full) begin
                    phase_next = PH_SYNC_A;
                end else if (head_end) begin
                    phase_next = (plen_next == 16'd0) ? PH_CRC0 : PH_DATA;
                end
            end
            PH_DATA: begin
                if (frame_full) begin
                    phase_next = PH_SYNC_A;
                end else if (data_end) begin
                    phase_next = PH_CRC0;
                end
            end
            PH_CRC0: phase_next = PH_CRC1;
            PH_CRC1: phase_next = PH_CRC2;
            PH_CRC2: phase_next = PH_CRC3;
            PH_CRC3: phase_next = PH_SYNC_A;
            default: phase_next = PH_SYNC_A;
        endcase
    end

    // Datapath and result
    always_comb begin
        count_next = count_reg;
        hlen_next  = hlen_reg;
        plen_next  = plen_reg;
        ident_next = ident_reg;
        crc_next   = crc_reg;
        rcrc_next  = rcrc_reg;
        res_next   = '0;
        res_next.byte_value = b;
        case (phase_reg)
            PH_SYNC_A: if (b == SYNC_A) count_next = '0;
            PH_HLEN: begin
                hlen_next  = b;
                ident_next = '0;
                plen_next  = '0;
                if (b < HLEN_MIN) begin
                    res_next.framing_error = 1'b1;
                end else begin
                    crc_next   = crc_upd;
                    count_next = CW'(HDR_FIRST);
                end
            end
            PH_HEAD: begin
                if (head_full) begin
                    res_next.framing_error = 1'b1;
                end else begin
                    crc_next = crc_upd;
                    if (count_reg == CW'(HDR_ID_LO)) begin
                        ident_next[7:0] = b;
                    end else if (count_reg == CW'(HDR_ID_HI)) begin
                        ident_next[15:8] = b;
                    end else if (count_reg == CW'(HDR_LEN_LO)) begin
                        plen_next[7:0] = b;
                    end else if (count_reg == CW'(HDR_LEN_HI)) begin
                        plen_next[15:8] = b;
                    end
                    count_next = count_inc;
                end
            end
            PH_DATA: begin
                if (frame_full) begin
                    res_next.framing_error = 1'b1;
                end else begin
                    crc_next = crc_upd;
                    res_next.is_payload    = 1'b1;
                    res_next.payload_index = pidx_full[7:0];
                    res_next.message_id    = ident_reg;
                    count_next = count_inc;
                end
            end
            PH_CRC0: rcrc_next = {24'd0, b};
            PH_CRC1: rcrc_next[15:8] = b;
            PH_CRC2: rcrc_next[23:16] = b;
            PH_CRC3: begin
                rcrc_next = rcrc_final;
                res_next.frame_done = 1'b1;
                res_next.message_id = ident_reg;
                if (rcrc_final == crc_reg) begin
                    res_next.crc_ok       = 1'b1;
                    res_next.frame_length = flen_full[8:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_SYNC_A;
            count_reg     <= '0;
            hlen_reg      <= '0;
            plen_reg      <= '0;
            ident_reg     <= '0;
            crc_reg       <= '0;
            rcrc_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                hlen_reg  <= hlen_next;
                plen_reg  <= plen_next;
                ident_reg <= ident_next;
                crc_reg   <= crc_next;
                rcrc_reg  <= rcrc_next;
            end
            if (take) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            res_reg <= res_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign result  = res_reg;

    // Abort never coincides with a payload or end-of-frame tag
    a_err_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && res_reg.framing_error |-> !res_reg.is_payload && !res_reg.frame_done)
        else $error("abort tagged together with payload or frame end");

    // A pass is only reported on the closing CRC byte
    a_ok_done: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && res_reg.crc_ok |-> res_reg.frame_done)
        else $error("crc_ok without frame_done");

    // Last CRC byte always returns to the hunt
    a_crc3_hunt: assert property (@(posedge aclk) disable iff (!aresetn)
        take && phase_reg == PH_CRC3 |=> phase_reg == PH_SYNC_A)
        else $error("no return to hunt after frame end");

    // Count never runs past the largest frame or header
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CNT_MAX))
        else $error("byte count out of range");

endmodule

FILE: hw/rtl/binary_frame_deframer_crc32_top.sv
// Byte-stream frame parser with CRC-32 check.
//
// Input channel (s_*): one received byte per request on s_rx_byte.
// Result channel (m_*): exactly one result per input byte: the byte echo,
// payload tag and index, frame-done with CRC pass and frame length, and
// an abort flag for short/oversized headers or frames over MAX_FRAME.
// Frames: preamble AA 44 12, header-length byte, rest of header (message
// ID at bytes 4-5, payload length at bytes 8-9, little-endian), payload,
// then a little-endian reflected CRC-32 over preamble, header and payload.
//
// Throughput: one byte per cycle unless m_ready stalls; byte-wide CRC
// update and phase logic sit between the input and result registers.
// Stall: while m_ready is low the result register holds; one more byte is
// taken into the input register, then s_ready drops until the result drains.
// Reset (aresetn low, synchronous): both registers empty, parser hunting for
// the first preamble byte, all frame state cleared.
module binary_frame_deframer_crc32_top #(
    parameter int MAX_FRAME  = 256,
    parameter int HEADER_MAX = 28
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_byte_value,
    output logic        m_is_payload,
    output logic [7:0]  m_payload_index,
    output logic        m_frame_done,
    output logic        m_crc_ok,
    output logic [15:0] m_message_id,
    output logic [8:0]  m_frame_length,
    output logic        m_framing_error
);
    import bfd_pkg::*;

    in_item_t item;
    logic     take;
    result_t  result;

    // Input register: decouples the sender from the parser stage
    bfd_in_reg u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .take      (take),
        .item      (item)
    );

    // Parser: phase machine, CRC, result register
    bfd_parser #(
        .MAX_FRAME  (MAX_FRAME),
        .HEADER_MAX (HEADER_MAX)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item    (item),
        .take    (take),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .result  (result)
    );

    assign m_byte_value    = result.byte_value;
    assign m_is_payload    = result.is_payload;
    assign m_payload_index = result.payload_index;
    assign m_frame_done    = result.frame_done;
    assign m_crc_ok        = result.crc_ok;
    assign m_message_id    = result.message_id;
    assign m_frame_length  = result.frame_length;
    assign m_framing_error = result.framing_error;

endmodule

FILE: tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bfd_pkg::*;

    localparam int MAX_FRAME    = 256;
    localparam int HEADER_MAX   = 28;
    localparam int ITEM_TARGET  = 1050;     // bytes that reach past the hunt
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 8;        // idle wait once no results are owed
    localparam int LONG_HOLD    = 80;       // receiver hold-off that backs up the input

    // Where a directed byte comes from: typed in, or one byte of the running CRC
    typedef enum logic {SRC_LITERAL, SRC_CRC} byte_src_t;

    typedef struct packed {
        byte_src_t  src;
        logic [7:0] value;      // the byte, or the CRC byte index for SRC_CRC
        logic       typed;      // 1: the result below is used instead of the predictor
        result_t    want;
    } directed_row_t;

    // Random frame shapes
    typedef enum {
        FR_GOOD, FR_BAD_CRC, FR_FULL, FR_OVER, FR_HDR_OVER,
        FR_SHORT_HLEN, FR_BROKEN_SYNC, FR_NOISE
    } frame_kind_t;

    // Directed stimulus. Rows with typed results are plain echoes in the hunt
    // or an abort; the frame at the end is left to the predictor.
    localparam directed_row_t DIRECTED_ROWS [21] = '{
        // bytes in the hunt: echo only, both extremes
        '{SRC_LITERAL, 8'h00, 1'b1, '{8'h00, 1'b0, 8'd0, 1'b0, 1'b0, 16'd0, 9'd0, 1'b0}},
        '{SRC_LITERAL, 8'hFF, 1'b1, '{8'hFF, 1'b0, 8'd0, 1'b0, 1'b0, 16'd0, 9'd0, 1'b0}},
        // preamble then header length 4: short header abort
        '{SRC_LITERAL, 8'hAA, 1'b1, '{8'hAA, 1'b0, 8'd0, 1'b0, 1'b0, 16'd0, 9'd0, 1'b0}},
        '{SRC_LITERAL, 8'h44, 1'b1, '{8'h44, 1'b0, 8'd0, 1'b0, 1'b0, 16'd0, 9'd0, 1'b0}},
        '{SRC_LITERAL, 8'h12, 1'b1, '{8'h12, 1'b0, 8'd0, 1'b0, 1'b0, 16'd0, 9'd0, 1'b0}},
        '{SRC_LITERAL, 8'h04, 1'b1, '{8'h04, 1'b0, 8'd0, 1'b0, 1'b0, 16'd0, 9'd0, 1'b1}},
        // wrong second preamble byte
        '{SRC_LITERAL, 8'hAA, 1'b1, '{8'hAA, 1'b0, 8'd0, 1'b0, 1'b0, 16'd0, 9'd0, 1'b0}},
        '{SRC_LITERAL, 8'h55, 1'b1, '{8'h55, 1'b0, 8'd0, 1'b0, 1'b0, 16'd0, 9'd0, 1'b0}},
        // wrong third byte is AA itself; it must not restart the preamble
        '{SRC_LITERAL, 8'hAA, 1'b1, '{8'hAA, 1'b0, 8'd0, 1'b0, 1'b0, 16'd0, 9'd0, 1'b0}},
        '{SRC_LITERAL, 8'h44, 1'b1, '{8'h44, 1'b0, 8'd0, 1'b0, 1'b0, 16'd0, 9'd0, 1'b0}},
        '{SRC_LITERAL, 8'hAA, 1'b1, '{8'hAA, 1'b0, 8'd0, 1'b0, 1'b0, 16'd0, 9'd0, 1'b0}},
        '{SRC_LITERAL, 8'h44, 1'b1, '{8'h44, 1'b0, 8'd0, 1'b0, 1'b0, 16'd0, 9'd0, 1'b0}},
        // shortest header (5): only the ID low byte, no payload, good CRC
        '{SRC_LITERAL, 8'hAA, 1'b0, '0},
        '{SRC_LITERAL, 8'h44, 1'b0, '0},
        '{SRC_LITERAL, 8'h12, 1'b0, '0},
        '{SRC_LITERAL, 8'h05, 1'b0, '0},
        '{SRC_LITERAL, 8'hFF, 1'b0, '0},
        '{SRC_CRC,     8'd0,  1'b0, '0},
        '{SRC_CRC,     8'd1,  1'b0, '0},
        '{SRC_CRC,     8'd2,  1'b0, '0},
        '{SRC_CRC,     8'd3,  1'b0, '0}
    };

    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte       = 8'h00;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic [7:0]  m_byte_value;
    logic        m_is_payload;
    logic [7:0]  m_payload_index;
    logic        m_frame_done;
    logic        m_crc_ok;
    logic [15:0] m_message_id;
    logic [8:0]  m_frame_length;
    logic        m_framing_error;

    binary_frame_deframer_crc32_top #(
        .MAX_FRAME  (MAX_FRAME),
        .HEADER_MAX (HEADER_MAX)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_byte_value    (m_byte_value),
        .m_is_payload    (m_is_payload),
        .m_payload_index (m_payload_index),
        .m_frame_done    (m_frame_done),
        .m_crc_ok        (m_crc_ok),
        .m_message_id    (m_message_id),
        .m_frame_length  (m_frame_length),
        .m_framing_error (m_framing_error)
    );

    always #4 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Parser state as the testbench sees it
    // ------------------------------------------------------------------
    phase_t      fp_phase   = PH_SYNC_A;
    logic [8:0]  fp_count   = '0;
    logic [7:0]  fp_hdr_len = '0;
    logic [15:0] fp_pay_len = '0;
    logic [15:0] fp_msg_id  = '0;
    logic [31:0] fp_crc     = '0;
    logic [31:0] fp_rx_crc  = '0;

    result_t pending_results [$];   // results still owed by the block, oldest first
    int      mismatches    = 0;
    int      counted_bytes = 0;     // requests that got past the hunt
    int      cycle_count   = 0;
    bit      steady_sender = 1'b0;  // no gaps on the sender for the current frame

    // Reflected CRC-32, bit-serial, one byte
    function automatic logic [31:0] crc32_feed(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Advances the parser by one byte and returns the result it owes
    function automatic result_t frame_parse(input logic [7:0] b);
        result_t r;
        r = '0;
        r.byte_value = b;
        case (fp_phase)
            PH_SYNC_A: begin
                if (b == SYNC_A) begin
                    fp_phase = PH_SYNC_B;
                    fp_count = '0;
                end
            end
            PH_SYNC_B: fp_phase = (b == SYNC_B) ? PH_SYNC_C : PH_SYNC_A;
            PH_SYNC_C: fp_phase = (b == SYNC_C) ? PH_HLEN : PH_SYNC_A;
            PH_HLEN: begin
                fp_hdr_len = b;
                fp_msg_id  = '0;
                fp_pay_len = '0;
                if (b < HLEN_MIN) begin
                    r.framing_error = 1'b1;
                    fp_phase = PH_SYNC_A;
                end else begin
                    fp_crc = crc32_feed(crc32_feed(crc32_feed(crc32_feed(32'd0, SYNC_A),
                                                              SYNC_B), SYNC_C), b);
                    fp_count = 9'(HDR_FIRST);
                    fp_phase = PH_HEAD;
                end
            end
            PH_HEAD: begin
                if (fp_count >= HEADER_MAX) begin
                    r.framing_error = 1'b1;
                    fp_phase = PH_SYNC_A;
                end else begin
                    fp_crc = crc32_feed(fp_crc, b);
                    case (int'(fp_count))
                        HDR_ID_LO:  fp_msg_id[7:0]   = b;
                        HDR_ID_HI:  fp_msg_id[15:8]  = b;
                        HDR_LEN_LO: fp_pay_len[7:0]  = b;
                        HDR_LEN_HI: fp_pay_len[15:8] = b;
                        default: ;
                    endcase
                    fp_count++;
                    if (fp_count >= fp_hdr_len) begin
                        fp_phase = (fp_pay_len == 16'd0) ? PH_CRC0 : PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                if (fp_count >= MAX_FRAME) begin
                    r.framing_error = 1'b1;
                    fp_phase = PH_SYNC_A;
                end else begin
                    fp_crc = crc32_feed(fp_crc, b);
                    r.is_payload    = 1'b1;
                    r.payload_index = 8'(fp_count - fp_hdr_len);
                    r.message_id    = fp_msg_id;
                    fp_count++;
                    if (int'(fp_count) >= int'(fp_pay_len) + int'(fp_hdr_len)) begin
                        fp_phase = PH_CRC0;
                    end
                end
            end
            PH_CRC0: begin
                fp_rx_crc = {24'd0, b};
                fp_phase = PH_CRC1;
            end
            PH_CRC1: begin
                fp_rx_crc[15:8] = b;
                fp_phase = PH_CRC2;
            end
            PH_CRC2: begin
                fp_rx_crc[23:16] = b;
                fp_phase = PH_CRC3;
            end
            PH_CRC3: begin
                fp_rx_crc[31:24] = b;
                r.frame_done   = 1'b1;
                r.message_id   = fp_msg_id;
                r.crc_ok       = (fp_rx_crc == fp_crc);
                r.frame_length = r.crc_ok ? fp_count : 9'd0;
                fp_phase = PH_SYNC_A;
            end
            default: fp_phase = PH_SYNC_A;
        endcase
        return r;
    endfunction

    // Mostly no gap, some short, a few long
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // ------------------------------------------------------------------
    // Sender: one request per byte. Valid is raised without looking at
    // ready and held with the byte steady until the request is taken.
    // The result is predicted at the edge that takes the request.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                             input result_t want = '0);
        int      gap;
        phase_t  was;
        result_t guess;
        gap = steady_sender ? 0 : idle_cycles();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        was   = fp_phase;
        guess = frame_parse(b);
        pending_results.push_back(typed ? want : guess);
        if (was != PH_SYNC_A || b == SYNC_A) counted_bytes++;
    endtask

    // One frame, or a piece of noise, of the given shape
    task automatic send_frame(input frame_kind_t kind);
        logic [7:0]  hlen;
        logic [7:0]  b;
        logic [15:0] id;
        logic [15:0] plen;
        logic [31:0] crc_flip;
        int          plen_eff;
        int          n_hdr;
        int          r;

        case (kind)
            FR_NOISE: begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
                return;
            end
            FR_BROKEN_SYNC: begin
                send_byte(SYNC_A);
                b = ($urandom_range(0, 2) == 0) ? SYNC_A : 8'($urandom_range(0, 255));
                if ($urandom_range(0, 1) == 1) begin
                    send_byte(SYNC_B);
                    if (b == SYNC_C) b ^= 8'h01;
                end else if (b == SYNC_B) begin
                    b ^= 8'h01;
                end
                send_byte(b);
                return;
            end
            FR_SHORT_HLEN: begin
                send_byte(SYNC_A);
                send_byte(SYNC_B);
                send_byte(SYNC_C);
                send_byte(8'($urandom_range(0, HLEN_MIN - 1)));
                return;
            end
            default: ;
        endcase

        // header length: mostly the usual 10.., some shorter, the extremes now and then
        r = $urandom_range(0, 9);
        if (kind == FR_HDR_OVER) begin
            hlen = ($urandom_range(0, 2) == 0) ? 8'd255 : 8'($urandom_range(HEADER_MAX + 1, 254));
        end else if (kind == FR_FULL || kind == FR_OVER) begin
            hlen = 8'($urandom_range(HDR_LEN_HI + 1, HEADER_MAX));
        end else if (r < 6) begin
            hlen = 8'($urandom_range(10, 14));
        end else if (r == 6) begin
            hlen = HLEN_MIN;
        end else if (r == 7) begin
            hlen = 8'($urandom_range(6, 9));
        end else if (r == 8) begin
            hlen = 8'($urandom_range(15, HEADER_MAX - 1));
        end else begin
            hlen = 8'(HEADER_MAX);
        end

        case (kind)
            FR_FULL: plen = 16'(MAX_FRAME - hlen);
            FR_OVER: plen = ($urandom_range(0, 1) == 1) ? 16'(MAX_FRAME - hlen + 1)
                                                        : 16'($urandom_range(MAX_FRAME, 65535));
            default: begin
                r = $urandom_range(0, 9);
                plen = (r < 2) ? 16'd0 : (r < 8) ? 16'($urandom_range(1, 8))
                                                 : 16'($urandom_range(9, 40));
            end
        endcase
        id = 16'($urandom_range(0, 65535));

        // a header too short for the length field leaves part or all of it zero
        plen_eff = (hlen > HDR_LEN_HI) ? int'(plen) : (hlen > HDR_LEN_LO) ? int'(plen[7:0]) : 0;

        send_byte(SYNC_A);
        send_byte(SYNC_B);
        send_byte(SYNC_C);
        send_byte(hlen);

        // an oversized header stops at the byte that trips the abort
        n_hdr = (hlen > HEADER_MAX) ? HEADER_MAX - HDR_FIRST + 1 : int'(hlen) - HDR_FIRST;
        for (int i = HDR_FIRST; i < HDR_FIRST + n_hdr; i++) begin
            case (i)
                HDR_ID_LO:  b = id[7:0];
                HDR_ID_HI:  b = id[15:8];
                HDR_LEN_LO: b = plen[7:0];
                HDR_LEN_HI: b = plen[15:8];
                default:    b = 8'($urandom_range(0, 255));
            endcase
            send_byte(b);
        end
        if (hlen > HEADER_MAX) return;

        // a frame past MAX_FRAME stops at the payload byte that trips the abort
        if (plen_eff + int'(hlen) > MAX_FRAME) begin
            repeat (MAX_FRAME - int'(hlen) + 1) send_byte(8'($urandom_range(0, 255)));
            return;
        end
        repeat (plen_eff) send_byte(8'($urandom_range(0, 255)));

        // CRC from the running value; a bad frame gets one bit flipped
        crc_flip = (kind == FR_BAD_CRC) ? (32'd1 << $urandom_range(0, 31)) : 32'd0;
        for (int k = 0; k < 4; k++) begin
            send_byte(fp_crc[8*k +: 8] ^ crc_flip[8*k +: 8]);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls on m_ready, with one long hold-off once the
    // run is under way so the block backs up and drops s_ready.
    // ------------------------------------------------------------------
    initial begin
        int  stall;
        bit  held_long;
        held_long = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (!held_long && counted_bytes >= 300) begin
                held_long = 1'b1;
                stall = LONG_HOLD;
            end else begin
                stall = idle_cycles();
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(50, 150)) @(posedge aclk);
            end else begin
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result check: every request taken on the result side is compared
    // with the oldest owed result, field by field.
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t ns: %s expected 0x%0h, actual 0x%0h", $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        result_t owed;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t ns: result expected none, actual byte 0x%0h",
                         $time, m_byte_value);
            end else begin
                owed = pending_results.pop_front();
                check_field("byte_value",    32'(owed.byte_value),    32'(m_byte_value));
                check_field("is_payload",    32'(owed.is_payload),    32'(m_is_payload));
                check_field("payload_index", 32'(owed.payload_index), 32'(m_payload_index));
                check_field("frame_done",    32'(owed.frame_done),    32'(m_frame_done));
                check_field("crc_ok",        32'(owed.crc_ok),        32'(m_crc_ok));
                check_field("message_id",    32'(owed.message_id),    32'(m_message_id));
                check_field("frame_length",  32'(owed.frame_length),  32'(m_frame_length));
                check_field("framing_error", 32'(owed.framing_error), 32'(m_framing_error));
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence: reset, directed rows, random frames, drain
    // ------------------------------------------------------------------
    initial begin
        directed_row_t row;
        logic [7:0]    b;
        frame_kind_t   kind;
        int            frames;
        int            r;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part runs without sender gaps for the first twelve rows
        steady_sender = 1'b1;
        for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
            row = DIRECTED_ROWS[i];
            if (i == 12) steady_sender = 1'b0;
            b = (row.src == SRC_CRC) ? fp_crc[8*row.value[1:0] +: 8] : row.value;
            send_byte(b, row.typed, row.want);
        end

        // random frames; the big shapes are forced once early on
        frames = 0;
        while (counted_bytes < ITEM_TARGET) begin
            frames++;
            steady_sender = ($urandom_range(0, 3) == 0);
            if (frames == 2) begin
                kind = FR_FULL;
            end else if (frames == 4) begin
                kind = FR_OVER;
            end else if (frames == 6) begin
                kind = FR_HDR_OVER;
            end else begin
                r = $urandom_range(0, 99);
                kind = (r < 56) ? FR_GOOD :
                       (r < 69) ? FR_BAD_CRC :
                       (r < 77) ? FR_NOISE :
                       (r < 85) ? FR_BROKEN_SYNC :
                       (r < 91) ? FR_SHORT_HLEN :
                       (r < 98) ? FR_HDR_OVER :
                       (r < 99) ? FR_FULL : FR_OVER;
            end
            send_frame(kind);
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/bfd_pkg.sv
hw/rtl/bfd_in_reg.sv
hw/rtl/bfd_crc_unit.sv
hw/rtl/bfd_parser.sv
hw/rtl/binary_frame_deframer_crc32_top.sv
tb/testbench.sv
